// ----- rtl/core/nta_pkg.sv -----
// ----------------------------------------------------------------------------
// Neighbour table package
// Shared types and fixed widths for the neighbour table with aging.
// ----------------------------------------------------------------------------
package nta_pkg;

  // Fixed field widths of the request and result ports.
  localparam int unsigned IFACE_W   = 2;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned OUT_CNT_W = 5;
  localparam int unsigned HELLO_W   = 7;
  // Dead interval is three hello intervals; the limit needs two extra bits.
  localparam int unsigned LIMIT_W   = HELLO_W + 2;

  localparam logic [HELLO_W-1:0] HELLO_RST = 7'd5;

  // Classification of an accepted request.
  typedef enum logic [1:0] {
    CMD_HELLO,
    CMD_TICK,
    CMD_SKIP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [IFACE_W-1:0] iface;
    logic [ID_W-1:0]    nbr_id;
    logic [ID_W-1:0]    address;
    logic [ID_W-1:0]    mask;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } back_state_e;

endpackage

// ----- rtl/core/nta_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/nta_front.sv -----
// ----------------------------------------------------------------------------
// Neighbour table front end
// Accepts requests and classifies them as hello, tick or ignored hello.
// ----------------------------------------------------------------------------
module nta_front import nta_pkg::*; #(
  parameter int unsigned NUM_IFACES = 4
) (
  input  logic               start_i,
  input  logic               full_i,
  input  logic               mode_i,
  input  logic [IFACE_W-1:0] iface_index_i,
  input  logic [ID_W-1:0]    neighbor_router_id_i,
  input  logic [ID_W-1:0]    neighbor_address_i,
  input  logic [ID_W-1:0]    neighbor_mask_i,
  output logic               busy_o,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic       iface_ok;
  logic [4:0] iface_ext;

  assign iface_ext = {3'b000, iface_index_i};
  assign iface_ok  = (iface_ext < 5'(NUM_IFACES));

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    cmd_o.iface   = iface_index_i;
    cmd_o.nbr_id  = neighbor_router_id_i;
    cmd_o.address = neighbor_address_i;
    cmd_o.mask    = neighbor_mask_i;
    if (mode_i) begin
      cmd_o.kind = CMD_TICK;
    end else if (iface_ok) begin
      cmd_o.kind = CMD_HELLO;
    end else begin
      cmd_o.kind = CMD_SKIP;
    end
  end

endmodule

// ----- rtl/core/nta_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// Neighbour table request queue
// Two-entry queue that decouples the front end from the table walker.
// ----------------------------------------------------------------------------
module nta_cmd_fifo import nta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic valid_o,
  output logic full_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_pop;

  assign valid_o = (fill_q != 2'd0);
  assign full_o  = (fill_q == 2'd2);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (!push_i && do_pop) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/core/nta_back.sv -----
// ----------------------------------------------------------------------------
// Neighbour table back end
// Walks the entry memory one entry per cycle to age, match or insert.
// ----------------------------------------------------------------------------
module nta_back import nta_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned NUM_IFACES  = 4,
  parameter int unsigned AGE_BITS    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  cmd_t                 cmd_i,
  output logic                 cmd_pop_o,
  input  logic [HELLO_W-1:0]   hello_interval_i,
  output logic                 done_o,
  output logic                 lsu_trigger_o,
  output logic                 neighbor_added_o,
  output logic [OUT_CNT_W-1:0] removed_count_o,
  output logic                 table_full_drop_o,
  output logic [OUT_CNT_W-1:0] iface_neighbor_count_o
);

  localparam int unsigned IDX_W    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IF_IDX_W = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
  localparam int unsigned WORD_W   = IFACE_W + 3 * ID_W + AGE_BITS;
  localparam int unsigned CMP_W    = (AGE_BITS > LIMIT_W) ? AGE_BITS : LIMIT_W;
  // Word layout, top down: interface, router id, address, mask, age.
  localparam int unsigned AGE_LO   = 0;
  localparam int unsigned MASK_LO  = AGE_BITS;
  localparam int unsigned ADDR_LO  = MASK_LO + ID_W;
  localparam int unsigned RID_LO   = ADDR_LO + ID_W;
  localparam int unsigned IF_LO    = RID_LO + ID_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  back_state_e state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic             issue_q, issue_d;
  logic             pend_q, pend_d;
  logic             hit_q, hit_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [CNT_W-1:0] removed_q, removed_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CNT_W-1:0] cnt_q [NUM_IFACES];

  logic                 done_q, done_d;
  logic                 trig_q, trig_d;
  logic                 added_q, added_d;
  logic [OUT_CNT_W-1:0] rem_out_q, rem_out_d;
  logic                 drop_q, drop_d;
  logic [OUT_CNT_W-1:0] cnt_out_q, cnt_out_d;

  // Memory ports.
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // Read entry decode.
  logic [IFACE_W-1:0]  rd_iface;
  logic [ID_W-1:0]     rd_rid;
  logic [AGE_BITS-1:0] rd_age, age_inc;
  logic [LIMIT_W-1:0]  limit;
  logic                ent_valid, match, expire, last, rd_iface_ok;
  logic [4:0]          rd_iface_ext, cur_iface_ext;

  // Interface counter access: one index per cycle.
  logic [IF_IDX_W-1:0] cnt_idx;
  logic [CNT_W-1:0]    cnt_rd, cnt_wval;
  logic                cnt_we;

  nta_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_iface = ram_rdata[IF_LO +: IFACE_W];
  assign rd_rid   = ram_rdata[RID_LO +: ID_W];
  assign rd_age   = ram_rdata[AGE_LO +: AGE_BITS];
  assign age_inc  = (rd_age == {AGE_BITS{1'b1}}) ? rd_age : rd_age + 1'b1;
  assign limit    = {2'b00, hello_interval_i} + {1'b0, hello_interval_i, 1'b0};
  assign expire   = (CMP_W'(age_inc) >= CMP_W'(limit));

  assign ent_valid = valid_q[pidx_q];
  assign match     = ent_valid && (rd_iface == cur_q.iface) && (rd_rid == cur_q.nbr_id);
  assign last      = (pidx_q == LAST_IDX);

  assign rd_iface_ext  = {3'b000, rd_iface};
  assign cur_iface_ext = {3'b000, cur_q.iface};
  assign rd_iface_ok   = (rd_iface_ext < 5'(NUM_IFACES));
  assign cnt_idx       = (state_q == ST_WALK) ? rd_iface_ext[IF_IDX_W-1:0]
                                              : cur_iface_ext[IF_IDX_W-1:0];
  assign cnt_rd        = cnt_q[cnt_idx];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.kind == CMD_SKIP) ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (pend_q && (last || (cur_q.kind == CMD_HELLO && match))) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_pop_o    = 1'b0;
    cur_d        = cur_q;
    idx_d        = idx_q;
    pidx_d       = pidx_q;
    issue_d      = issue_q;
    pend_d       = 1'b0;
    hit_d        = hit_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    removed_d    = removed_q;
    valid_d      = valid_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = pidx_q;
    ram_wdata    = ram_rdata;
    cnt_we       = 1'b0;
    cnt_wval     = cnt_rd;
    done_d       = 1'b0;
    trig_d       = trig_q;
    added_d      = added_q;
    rem_out_d    = rem_out_q;
    drop_d       = drop_q;
    cnt_out_d    = cnt_out_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_pop_o    = cmd_valid_i;
        cur_d        = cmd_i;
        idx_d        = '0;
        issue_d      = 1'b1;
        hit_d        = 1'b0;
        free_found_d = 1'b0;
        removed_d    = '0;
      end
      ST_WALK: begin
        ram_re = issue_q;
        if (issue_q) begin
          pend_d = 1'b1;
          pidx_d = idx_q;
          if (idx_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (pend_q) begin
          if (cur_q.kind == CMD_TICK) begin
            if (ent_valid) begin
              ram_we    = 1'b1;
              ram_wdata = {ram_rdata[WORD_W-1:AGE_BITS], age_inc};
              if (expire) begin
                valid_d[pidx_q] = 1'b0;
                removed_d       = removed_q + 1'b1;
                if (rd_iface_ok && cnt_rd != '0) begin
                  cnt_we   = 1'b1;
                  cnt_wval = cnt_rd - 1'b1;
                end
              end
            end
          end else if (match) begin
            ram_we    = 1'b1;
            ram_wdata = {ram_rdata[WORD_W-1:AGE_BITS], {AGE_BITS{1'b0}}};
            hit_d     = 1'b1;
            issue_d   = 1'b0;
          end else if (!ent_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = pidx_q;
          end
        end
      end
      ST_FINISH: begin
        done_d    = 1'b1;
        trig_d    = 1'b0;
        added_d   = 1'b0;
        rem_out_d = '0;
        drop_d    = 1'b0;
        cnt_out_d = '0;
        case (cur_q.kind)
          CMD_TICK: begin
            trig_d    = (removed_q != '0);
            rem_out_d = OUT_CNT_W'(removed_q);
          end
          CMD_HELLO: begin
            cnt_out_d = OUT_CNT_W'(cnt_rd);
            if (!hit_q) begin
              if (free_found_q) begin
                ram_we              = 1'b1;
                ram_waddr           = free_idx_q;
                ram_wdata           = {cur_q.iface, cur_q.nbr_id, cur_q.address,
                                       cur_q.mask, {AGE_BITS{1'b0}}};
                valid_d[free_idx_q] = 1'b1;
                cnt_we              = 1'b1;
                cnt_wval            = cnt_rd + 1'b1;
                cnt_out_d           = OUT_CNT_W'(cnt_wval);
                trig_d              = 1'b1;
                added_d             = 1'b1;
              end else begin
                drop_d = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      issue_q <= 1'b0;
      pend_q  <= 1'b0;
      valid_q <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < NUM_IFACES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      if (cnt_we) begin
        cnt_q[cnt_idx] <= cnt_wval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    idx_q        <= idx_d;
    pidx_q       <= pidx_d;
    hit_q        <= hit_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    removed_q    <= removed_d;
    trig_q       <= trig_d;
    added_q      <= added_d;
    rem_out_q    <= rem_out_d;
    drop_q       <= drop_d;
    cnt_out_q    <= cnt_out_d;
  end

  assign done_o                 = done_q;
  assign lsu_trigger_o          = trig_q;
  assign neighbor_added_o       = added_q;
  assign removed_count_o        = rem_out_q;
  assign table_full_drop_o      = drop_q;
  assign iface_neighbor_count_o = cnt_out_q;

endmodule

// ----- rtl/core/neighbor_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// Neighbour table with aging
// Hello-driven neighbour table with dead-interval expiry on ticks.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o rises
// only when the two-entry request queue is full, so up to two requests may
// be posted while the table walker is still working. Each request yields
// exactly one result, shown for a single cycle with done_o high; the
// receiver cannot hold it off and must take it in that cycle. The walker
// reads the entry memory through its single read port with registered
// read data, one entry per cycle. A tick or a hello for a new neighbour
// walks the whole table, a hello that matches an entry ends the walk
// there, and a hello on an interface beyond NUM_IFACES skips the walk.
// The table needs no clearing pass after reset: per-entry valid bits in
// flip-flops are cleared at once. The hello interval register is written
// with hello_interval_we_i and should be changed only while the block is
// idle.
module neighbor_table_with_aging import nta_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned NUM_IFACES  = 4,
  parameter int unsigned AGE_BITS    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 hello_interval_we_i,
  input  logic [HELLO_W-1:0]   hello_interval_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 mode_i,
  input  logic [IFACE_W-1:0]   iface_index_i,
  input  logic [ID_W-1:0]      neighbor_router_id_i,
  input  logic [ID_W-1:0]      neighbor_address_i,
  input  logic [ID_W-1:0]      neighbor_mask_i,
  output logic                 done_o,
  output logic                 lsu_trigger_o,
  output logic                 neighbor_added_o,
  output logic [OUT_CNT_W-1:0] removed_count_o,
  output logic                 table_full_drop_o,
  output logic [OUT_CNT_W-1:0] iface_neighbor_count_o
);

  // The hello interval register; the dead limit is three times this value.
  logic [HELLO_W-1:0] hello_interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hello_interval_q <= HELLO_RST;
    end else if (hello_interval_we_i) begin
      hello_interval_q <= hello_interval_i;
    end
  end

  // Front end: takes the request and sorts it into a tick, a hello, or a
  // hello on a non-existent interface which only needs an all-zero result.
  logic push, fifo_full, fifo_valid, fifo_pop;
  cmd_t front_cmd, fifo_cmd;

  nta_front #(
    .NUM_IFACES (NUM_IFACES)
  ) u_front (
    .start_i              (start_i),
    .full_i               (fifo_full),
    .mode_i               (mode_i),
    .iface_index_i        (iface_index_i),
    .neighbor_router_id_i (neighbor_router_id_i),
    .neighbor_address_i   (neighbor_address_i),
    .neighbor_mask_i      (neighbor_mask_i),
    .busy_o               (busy_o),
    .push_o               (push),
    .cmd_o                (front_cmd)
  );

  // The queue lets the front end keep taking requests while the walker is
  // busy with an earlier one.
  nta_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (fifo_pop),
    .cmd_o   (fifo_cmd),
    .valid_o (fifo_valid),
    .full_o  (fifo_full)
  );

  // Back end: owns the entry memory, the valid bits and the per-interface
  // counts, and produces the registered result.
  nta_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_IFACES  (NUM_IFACES),
    .AGE_BITS    (AGE_BITS)
  ) u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_valid_i            (fifo_valid),
    .cmd_i                  (fifo_cmd),
    .cmd_pop_o              (fifo_pop),
    .hello_interval_i       (hello_interval_q),
    .done_o                 (done_o),
    .lsu_trigger_o          (lsu_trigger_o),
    .neighbor_added_o       (neighbor_added_o),
    .removed_count_o        (removed_count_o),
    .table_full_drop_o      (table_full_drop_o),
    .iface_neighbor_count_o (iface_neighbor_count_o)
  );

endmodule

// ----- rtl/core/nta_checker.sv -----
// ----------------------------------------------------------------------------
// Neighbour table checker
// Port-level assertions on the results of the neighbour table.
// ----------------------------------------------------------------------------
module nta_checker import nta_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 done_o,
  input logic                 lsu_trigger_o,
  input logic                 neighbor_added_o,
  input logic [OUT_CNT_W-1:0] removed_count_o,
  input logic                 table_full_drop_o,
  input logic [OUT_CNT_W-1:0] iface_neighbor_count_o
);

  // A new neighbour is either stored or dropped, never both.
  a_add_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(neighbor_added_o && table_full_drop_o))
    else $error("neighbour both added and dropped");

  // The trigger is raised exactly when something was added or removed.
  a_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (lsu_trigger_o == (neighbor_added_o || removed_count_o != 5'd0)))
    else $error("update trigger disagrees with table change");

  // Removals only come from ticks, which report no interface count.
  a_tick_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && removed_count_o != 5'd0) |->
      (iface_neighbor_count_o == 5'd0 && !table_full_drop_o && !neighbor_added_o))
    else $error("hello fields set on an expiring tick");

  // The result strobe is never held high back to back.
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

endmodule

bind neighbor_table_with_aging nta_checker u_nta_checker (.*);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Neighbour table testbench
// Sends hello and tick requests to the neighbour table, keeps a shadow copy
// of the table, its ages and its per-interface counts, and checks every
// result strobe field by field against the outcome worked out from it or typed by hand.
// ----------------------------------------------------------------------------
module tb;
  import nta_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned NUM_IFACES  = 4;
  localparam int unsigned AGE_BITS    = 8;
  localparam logic [AGE_BITS-1:0] AGE_CEILING = '1;
  localparam int unsigned DEAD_FACTOR = 3;

  localparam logic MODE_HELLO = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // A tick or a hello for a new neighbour walks the whole table.
  localparam int unsigned WALK_CYCLES    = TABLE_DEPTH + 3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ID_POOL_SIZE   = 24;

  typedef enum logic [1:0] {
    ROW_HELLO,
    ROW_TICK,
    ROW_SET_INTERVAL
  } row_kind_e;

  // One result of the block, in port order.
  typedef struct packed {
    logic                 lsu_trigger;
    logic                 neighbor_added;
    logic [OUT_CNT_W-1:0] removed_count;
    logic                 table_full_drop;
    logic [OUT_CNT_W-1:0] iface_count;
  } outcome_t;

  // One row of the directed table. Rows marked typed carry an outcome that
  // is written out by hand; the others are checked against the shadow table.
  typedef struct {
    row_kind_e          kind;
    logic [IFACE_W-1:0] iface;
    logic [ID_W-1:0]    nbr_id;
    logic [ID_W-1:0]    address;
    logic [ID_W-1:0]    mask;
    logic [HELLO_W-1:0] interval;
    bit                 typed;
    outcome_t           outcome;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 hello_interval_we_i = 1'b0;
  logic [HELLO_W-1:0]   hello_interval_i = '0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic                 mode_i = MODE_HELLO;
  logic [IFACE_W-1:0]   iface_index_i = '0;
  logic [ID_W-1:0]      neighbor_router_id_i = '0;
  logic [ID_W-1:0]      neighbor_address_i = '0;
  logic [ID_W-1:0]      neighbor_mask_i = '0;
  logic                 done_o;
  logic                 lsu_trigger_o;
  logic                 neighbor_added_o;
  logic [OUT_CNT_W-1:0] removed_count_o;
  logic                 table_full_drop_o;
  logic [OUT_CNT_W-1:0] iface_neighbor_count_o;

  // Shadow copy of the neighbour table and the hello interval register.
  logic                 shadow_valid   [TABLE_DEPTH];
  logic [IFACE_W-1:0]   shadow_iface   [TABLE_DEPTH];
  logic [ID_W-1:0]      shadow_nbr_id  [TABLE_DEPTH];
  logic [ID_W-1:0]      shadow_address [TABLE_DEPTH];
  logic [ID_W-1:0]      shadow_mask    [TABLE_DEPTH];
  logic [AGE_BITS-1:0]  shadow_age     [TABLE_DEPTH];
  logic [OUT_CNT_W-1:0] shadow_count   [NUM_IFACES];
  logic [HELLO_W-1:0]   shadow_interval;

  outcome_t       awaited_outcomes[$];
  stim_row_t      directed_rows[$];
  logic [ID_W-1:0] id_pool [ID_POOL_SIZE];
  int unsigned    error_count = 0;
  int unsigned    idle_cycles = 0;
  bit             no_idle_run = 1'b0;

  always #2 clk_i = ~clk_i;

  neighbor_table_with_aging uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .hello_interval_we_i    (hello_interval_we_i),
    .hello_interval_i       (hello_interval_i),
    .start_i                (start_i),
    .busy_o                 (busy_o),
    .mode_i                 (mode_i),
    .iface_index_i          (iface_index_i),
    .neighbor_router_id_i   (neighbor_router_id_i),
    .neighbor_address_i     (neighbor_address_i),
    .neighbor_mask_i        (neighbor_mask_i),
    .done_o                 (done_o),
    .lsu_trigger_o          (lsu_trigger_o),
    .neighbor_added_o       (neighbor_added_o),
    .removed_count_o        (removed_count_o),
    .table_full_drop_o      (table_full_drop_o),
    .iface_neighbor_count_o (iface_neighbor_count_o)
  );

  // Applies one request to the shadow table and returns the result the
  // block should give for it. A tick ages every live entry, saturating at
  // the top of the age range, and drops those that reach three hello
  // intervals. A hello refreshes a matching entry on its interface, or
  // else takes the lowest free slot, or else is dropped as the table is full.
  function automatic outcome_t step_neighbor_table(logic mode, logic [IFACE_W-1:0] ifc,
                                                   logic [ID_W-1:0] rid,
                                                   logic [ID_W-1:0] addr,
                                                   logic [ID_W-1:0] msk);
    outcome_t           res;
    int                 hit;
    int                 free_slot;
    int unsigned        gone;
    logic [LIMIT_W-1:0] dead_limit;
    res        = '0;
    hit        = -1;
    free_slot  = -1;
    gone       = 0;
    dead_limit = LIMIT_W'(DEAD_FACTOR * shadow_interval);
    if (mode == MODE_TICK) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (shadow_valid[i]) begin
          if (shadow_age[i] != AGE_CEILING) begin
            shadow_age[i]++;
          end
          if (LIMIT_W'(shadow_age[i]) >= dead_limit) begin
            shadow_valid[i] = 1'b0;
            if (shadow_count[shadow_iface[i]] != 0) begin
              shadow_count[shadow_iface[i]]--;
            end
            gone++;
          end
        end
      end
      res.removed_count = OUT_CNT_W'(gone);
      res.lsu_trigger   = (gone != 0);
    end else if (int'(ifc) < NUM_IFACES) begin
      // With four interfaces on a two-bit index no hello is out of range.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (shadow_valid[i]) begin
          if (hit < 0 && shadow_iface[i] == ifc && shadow_nbr_id[i] == rid) begin
            hit = i;
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        // A known neighbour keeps its stored address and mask.
        shadow_age[hit] = '0;
      end else if (free_slot >= 0) begin
        shadow_valid[free_slot]   = 1'b1;
        shadow_iface[free_slot]   = ifc;
        shadow_nbr_id[free_slot]  = rid;
        shadow_address[free_slot] = addr;
        shadow_mask[free_slot]    = msk;
        shadow_age[free_slot]     = '0;
        shadow_count[ifc]++;
        res.lsu_trigger    = 1'b1;
        res.neighbor_added = 1'b1;
      end else begin
        res.table_full_drop = 1'b1;
      end
      res.iface_count = shadow_count[ifc];
    end
    return res;
  endfunction

  // Idle time after a request: mostly none or short, now and then long,
  // and none at all during a no-idle run.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle_run || roll < 50) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic stim_row_t hello_row(logic [IFACE_W-1:0] ifc, logic [ID_W-1:0] rid,
                                          logic [ID_W-1:0] addr, logic [ID_W-1:0] msk);
    stim_row_t r;
    r.kind     = ROW_HELLO;
    r.iface    = ifc;
    r.nbr_id   = rid;
    r.address  = addr;
    r.mask     = msk;
    r.interval = '0;
    r.typed    = 1'b0;
    r.outcome  = '0;
    return r;
  endfunction

  function automatic stim_row_t tick_row();
    stim_row_t r;
    r      = hello_row('0, '0, '0, '0);
    r.kind = ROW_TICK;
    return r;
  endfunction

  function automatic stim_row_t interval_row(logic [HELLO_W-1:0] v);
    stim_row_t r;
    r          = hello_row('0, '0, '0, '0);
    r.kind     = ROW_SET_INTERVAL;
    r.interval = v;
    return r;
  endfunction

  function automatic stim_row_t with_outcome(stim_row_t r, logic trig, logic added,
                                             logic [OUT_CNT_W-1:0] removed, logic drop,
                                             logic [OUT_CNT_W-1:0] cnt);
    r.typed   = 1'b1;
    r.outcome = '{trig, added, removed, drop, cnt};
    return r;
  endfunction

  // Presents one request, holds it until the block takes it, records the
  // result it should give and then idles for the given number of cycles.
  // With no idling start_i simply stays high for the next request.
  task automatic issue_request(logic mode, logic [IFACE_W-1:0] ifc, logic [ID_W-1:0] rid,
                               logic [ID_W-1:0] addr, logic [ID_W-1:0] msk,
                               bit typed, outcome_t typed_outcome, int unsigned gap);
    outcome_t predicted;
    start_i              <= 1'b1;
    mode_i               <= mode;
    iface_index_i        <= ifc;
    neighbor_router_id_i <= rid;
    neighbor_address_i   <= addr;
    neighbor_mask_i      <= msk;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    predicted = step_neighbor_table(mode, ifc, rid, addr, msk);
    awaited_outcomes.push_back(typed ? typed_outcome : predicted);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The interval register is only changed once every outstanding request
  // has produced its result, so the block is idle when it is written.
  task automatic set_hello_interval(logic [HELLO_W-1:0] v);
    start_i <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    hello_interval_we_i <= 1'b1;
    hello_interval_i    <= v;
    @(posedge clk_i);
    hello_interval_we_i <= 1'b0;
    shadow_interval = v;
  endtask

  // Random hellos and ticks. Router ids mostly come from a small pool, so
  // that hellos often refresh known neighbours and the table fills up; now
  // and then a fresh id is drawn. Every field is random on ticks as well.
  task automatic random_items(int unsigned count, int unsigned tick_pct);
    logic               is_tick;
    logic [IFACE_W-1:0] ifc;
    logic [ID_W-1:0]    rid;
    for (int k = 0; k < count; k++) begin
      if (k % 32 == 0) begin
        no_idle_run = ($urandom_range(0, 3) == 0);
      end
      is_tick = ($urandom_range(0, 99) < tick_pct);
      ifc     = IFACE_W'($urandom_range(0, NUM_IFACES - 1));
      if ($urandom_range(0, 9) == 0) begin
        rid = $urandom();
      end else begin
        rid = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
      end
      issue_request(is_tick ? MODE_TICK : MODE_HELLO, ifc, rid, $urandom(), $urandom(),
                    1'b0, '0, pick_gap());
    end
  endtask

  // Compares one result field; an X or Z on the port counts as a mismatch.
  function automatic void check_field(string field, logic [OUT_CNT_W-1:0] want,
                                      logic [OUT_CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endfunction

  // Result checker. Every strobe must match the oldest outstanding request.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (awaited_outcomes.size() == 0) begin
        $error("result strobe with no request outstanding");
        error_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        check_field("lsu_trigger", OUT_CNT_W'(want.lsu_trigger), OUT_CNT_W'(lsu_trigger_o));
        check_field("neighbor_added", OUT_CNT_W'(want.neighbor_added),
                    OUT_CNT_W'(neighbor_added_o));
        check_field("removed_count", want.removed_count, removed_count_o);
        check_field("table_full_drop", OUT_CNT_W'(want.table_full_drop),
                    OUT_CNT_W'(table_full_drop_o));
        check_field("iface_neighbor_count", want.iface_count, iface_neighbor_count_o);
      end
    end
  end

  // Watchdog: ends the run if neither a request nor a result moves for too
  // long. Sender gaps, configuration pauses and the longest walk fit well
  // inside the limit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t row;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_valid[i]   = 1'b0;
      shadow_iface[i]   = '0;
      shadow_nbr_id[i]  = '0;
      shadow_address[i] = '0;
      shadow_mask[i]    = '0;
      shadow_age[i]     = '0;
    end
    for (int f = 0; f < NUM_IFACES; f++) begin
      shadow_count[f] = '0;
    end
    shadow_interval = HELLO_RST;
    foreach (id_pool[p]) begin
      id_pool[p] = $urandom();
    end

    // Directed part, started with the interval at its reset value. A tick
    // on the empty table, a first neighbour at the all-zero extremes, a
    // refresh that must not count as new, the same id on another interface,
    // the all-ones extremes, then the table filled to the brim so that a
    // new neighbour is dropped while a known one is still refreshed.
    directed_rows.push_back(with_outcome(tick_row(), 1'b0, 1'b0, 5'd0, 1'b0, 5'd0));
    directed_rows.push_back(with_outcome(hello_row(2'd0, 32'h0, 32'h0, 32'h0),
                                         1'b1, 1'b1, 5'd0, 1'b0, 5'd1));
    directed_rows.push_back(with_outcome(hello_row(2'd0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                                         1'b0, 1'b0, 5'd0, 1'b0, 5'd1));
    directed_rows.push_back(with_outcome(hello_row(2'd1, 32'h0, 32'h1234_5678, 32'hFFFF_FF00),
                                         1'b1, 1'b1, 5'd0, 1'b0, 5'd1));
    directed_rows.push_back(with_outcome(hello_row(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                   32'hFFFF_FFFF),
                                         1'b1, 1'b1, 5'd0, 1'b0, 5'd1));
    directed_rows.push_back(with_outcome(hello_row(2'd2, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                                   32'hFFFF_FFFC),
                                         1'b1, 1'b1, 5'd0, 1'b0, 5'd1));
    for (int n = 1; n <= 12; n++) begin
      directed_rows.push_back(hello_row(2'd3, ID_W'(n), 32'h0A00_0000 | ID_W'(n),
                                        32'hFFFF_FF00));
    end
    directed_rows.push_back(with_outcome(hello_row(2'd2, 32'h8765_4321, 32'hC0A8_0001,
                                                   32'hFFFF_0000),
                                         1'b0, 1'b0, 5'd0, 1'b1, 5'd1));
    directed_rows.push_back(hello_row(2'd3, 32'd5, 32'h0B00_0005, 32'hFFFF_FF00));
    directed_rows.push_back(tick_row());
    // A zero interval makes every tick clear the whole table.
    directed_rows.push_back(interval_row(7'd0));
    directed_rows.push_back(with_outcome(tick_row(), 1'b1, 1'b0, 5'd16, 1'b0, 5'd0));
    directed_rows.push_back(with_outcome(hello_row(2'd0, 32'd7, 32'h0A00_0007, 32'hFF00_0000),
                                         1'b1, 1'b1, 5'd0, 1'b0, 5'd1));
    directed_rows.push_back(with_outcome(tick_row(), 1'b1, 1'b0, 5'd1, 1'b0, 5'd0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_SET_INTERVAL) begin
        set_hello_interval(row.interval);
      end else begin
        issue_request((row.kind == ROW_TICK) ? MODE_TICK : MODE_HELLO, row.iface,
                      row.nbr_id, row.address, row.mask, row.typed, row.outcome,
                      pick_gap());
      end
    end

    // Random part, one phase per interval setting. Short intervals give
    // frequent expiry. The phase at 86 puts the dead interval beyond the
    // age range, so ages saturate and nothing expires however long the
    // ticks go on; the phase at 85 that follows puts the limit right on the
    // saturated age, so those entries go on the first tick.
    set_hello_interval(7'd1);
    random_items(150, 30);
    set_hello_interval(7'd2);
    random_items(120, 40);
    set_hello_interval(7'd86);
    random_items(10, 0);
    random_items(262, 100);
    random_items(10, 0);
    set_hello_interval(7'd85);
    random_items(20, 70);
    set_hello_interval(7'd0);
    random_items(60, 30);
    set_hello_interval(7'd127);
    random_items(60, 20);
    repeat (3) begin
      set_hello_interval(HELLO_W'($urandom_range(1, 6)));
      random_items(100, 35);
    end

    start_i <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (2 * WALK_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/nta_pkg.sv
rtl/core/nta_ram.sv
rtl/core/nta_front.sv
rtl/core/nta_cmd_fifo.sv
rtl/core/nta_back.sv
rtl/core/neighbor_table_with_aging.sv
rtl/core/nta_checker.sv
verif/tb.sv
